FILE: rtl/pmsm_pkg.sv
// Shared types, codes and the mode transition table of the power mode controller.
package pmsm_pkg;

  typedef enum logic [8:0] {
    MODE_DEEPSLEEP  = 9'b000000001,
    MODE_SLEEP      = 9'b000000010,
    MODE_IDLE       = 9'b000000100,
    MODE_SAFETYLOCK = 9'b000001000,
    MODE_LOWV       = 9'b000010000,
    MODE_EMERGENCY  = 9'b000100000,
    MODE_CHARGING   = 9'b001000000,
    MODE_MANUAL     = 9'b010000000,
    MODE_ERROR      = 9'b100000000
  } mode_t;

  localparam logic [3:0] CODE_DEEPSLEEP  = 4'd0;
  localparam logic [3:0] CODE_SLEEP      = 4'd1;
  localparam logic [3:0] CODE_IDLE       = 4'd2;
  localparam logic [3:0] CODE_SAFETYLOCK = 4'd3;
  localparam logic [3:0] CODE_LOWV       = 4'd4;
  localparam logic [3:0] CODE_EMERGENCY  = 4'd5;
  localparam logic [3:0] CODE_CHARGING   = 4'd6;
  localparam logic [3:0] CODE_MANUAL     = 4'd7;
  localparam logic [3:0] CODE_ERROR      = 4'd8;
  localparam logic [3:0] NO_MODE         = 4'd9;
  localparam logic [3:0] MODE_COUNT      = 4'd9;

  localparam logic [4:0] EVENT_COUNT   = 5'd19;
  localparam logic [4:0] EV_LOCK       = 5'd11;
  localparam logic [4:0] EV_SOC_OK     = 5'd12;
  localparam logic [4:0] EV_UNLOCK     = 5'd13;
  localparam logic [4:0] EV_OVERCHARGE = 5'd18;

  localparam logic CMD_FIRE   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] SOC_NONE   = 2'd0;
  localparam logic [1:0] SOC_LOWV   = 2'd1;
  localparam logic [1:0] SOC_SAFETY = 2'd2;

  localparam logic [1:0] CFG_LOW_VOLTAGE = 2'd0;
  localparam logic [1:0] CFG_SAFETY      = 2'd1;

  localparam logic [6:0] EN_USBA1     = 7'h01;
  localparam logic [6:0] EN_USBA2     = 7'h02;
  localparam logic [6:0] EN_USBC2     = 7'h04;
  localparam logic [6:0] EN_STPD      = 7'h08;
  localparam logic [6:0] EN_OTG       = 7'h10;
  localparam logic [6:0] EN_BACKLIGHT = 7'h20;
  localparam logic [6:0] EN_LAB       = 7'h40;
  localparam logic [6:0] EN_POWER     = EN_USBA1 | EN_USBA2 | EN_USBC2 | EN_STPD | EN_OTG;
  localparam logic [6:0] EN_RESET     = EN_USBA1 | EN_USBA2 | EN_BACKLIGHT;

  localparam logic [6:0] LOW_VOLTAGE_RESET = 7'd5;
  localparam logic [6:0] SAFETY_RESET      = 7'd15;

  // next mode code by [current mode code][event], NO_MODE where there is no transition
  localparam logic [3:0] NEXT_MODE [9][19] = '{
    '{4'd2, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
      4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9},
    '{4'd6, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd5, 4'd8, 4'd0, 4'd9,
      4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9},
    '{4'd6, 4'd9, 4'd3, 4'd4, 4'd5, 4'd8, 4'd5, 4'd8, 4'd0, 4'd1,
      4'd7, 4'd3, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9},
    '{4'd6, 4'd9, 4'd9, 4'd4, 4'd5, 4'd8, 4'd5, 4'd8, 4'd9, 4'd9,
      4'd9, 4'd9, 4'd2, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9},
    '{4'd6, 4'd9, 4'd9, 4'd9, 4'd5, 4'd8, 4'd5, 4'd8, 4'd9, 4'd1,
      4'd9, 4'd9, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9},
    '{4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
      4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9},
    '{4'd9, 4'd9, 4'd3, 4'd4, 4'd5, 4'd8, 4'd5, 4'd8, 4'd9, 4'd1,
      4'd7, 4'd9, 4'd9, 4'd9, 4'd2, 4'd3, 4'd9, 4'd9, 4'd9},
    '{4'd9, 4'd9, 4'd3, 4'd4, 4'd5, 4'd8, 4'd5, 4'd8, 4'd9, 4'd9,
      4'd9, 4'd3, 4'd9, 4'd9, 4'd9, 4'd9, 4'd2, 4'd9, 4'd9},
    '{4'd6, 4'd2, 4'd3, 4'd4, 4'd5, 4'd9, 4'd5, 4'd9, 4'd9, 4'd9,
      4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd2, 4'd9}
  };

  typedef struct packed {
    logic       command;
    logic [4:0] event_code;
    logic       charger_sinking;
    logic       gauge_valid;
    logic [6:0] state_of_charge;
  } cmd_t;

  typedef struct packed {
    logic [3:0] current_mode;
    logic [3:0] pending_mode;
    logic [6:0] output_enables;
    logic       overcharge_warning;
    logic       user_lock_set;
    logic       unlock_refused;
    logic       transition_accepted;
    logic       raise_charger_event;
    logic [1:0] raise_soc_event;
  } rsp_t;

  function automatic logic [3:0] mode_to_code(input mode_t m);
    logic [3:0] c;
    unique case (m)
      MODE_DEEPSLEEP:  c = CODE_DEEPSLEEP;
      MODE_SLEEP:      c = CODE_SLEEP;
      MODE_IDLE:       c = CODE_IDLE;
      MODE_SAFETYLOCK: c = CODE_SAFETYLOCK;
      MODE_LOWV:       c = CODE_LOWV;
      MODE_EMERGENCY:  c = CODE_EMERGENCY;
      MODE_CHARGING:   c = CODE_CHARGING;
      MODE_MANUAL:     c = CODE_MANUAL;
      MODE_ERROR:      c = CODE_ERROR;
      default:         c = NO_MODE;
    endcase
    return c;
  endfunction

  function automatic mode_t code_to_mode(input logic [3:0] c);
    mode_t m;
    unique case (c)
      CODE_DEEPSLEEP:  m = MODE_DEEPSLEEP;
      CODE_SLEEP:      m = MODE_SLEEP;
      CODE_IDLE:       m = MODE_IDLE;
      CODE_SAFETYLOCK: m = MODE_SAFETYLOCK;
      CODE_LOWV:       m = MODE_LOWV;
      CODE_EMERGENCY:  m = MODE_EMERGENCY;
      CODE_CHARGING:   m = MODE_CHARGING;
      CODE_MANUAL:     m = MODE_MANUAL;
      CODE_ERROR:      m = MODE_ERROR;
      default:         m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/pmsm_core.sv
// Mode state, flags, enables and thresholds with the single-pass request evaluation.
module pmsm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              go,
  input  pmsm_pkg::cmd_t    item,
  output pmsm_pkg::rsp_t    result
);

  pmsm_pkg::mode_t mode_reg, mode_next;
  pmsm_pkg::mode_t pending_reg, pending_next;
  logic            overcharge_reg, overcharge_next;
  logic            lock_reg, lock_next;
  logic [6:0]      enables_reg, enables_next;
  logic [6:0]      low_voltage_thr;
  logic [6:0]      safety_thr;

  logic [3:0] mode_code;
  logic [3:0] nx;
  logic       refused;
  logic       accepted;
  logic       chg;
  logic [1:0] soc;

  always_comb begin
    mode_next       = mode_reg;
    pending_next    = pending_reg;
    overcharge_next = overcharge_reg;
    lock_next       = lock_reg;
    enables_next    = enables_reg;
    refused         = 1'b0;
    accepted        = 1'b0;
    chg             = 1'b0;
    soc             = pmsm_pkg::SOC_NONE;
    nx              = pmsm_pkg::NO_MODE;
    mode_code       = pmsm_pkg::mode_to_code(mode_reg);
    if (item.command == pmsm_pkg::CMD_FIRE) begin
      if (item.event_code < pmsm_pkg::EVENT_COUNT) begin
        if (item.event_code == pmsm_pkg::EV_OVERCHARGE) overcharge_next = 1'b1;
        if (item.event_code == pmsm_pkg::EV_SOC_OK) overcharge_next = 1'b0;
        if (item.event_code == pmsm_pkg::EV_LOCK) lock_next = 1'b1;
        if (mode_code < pmsm_pkg::MODE_COUNT) begin
          nx = pmsm_pkg::NEXT_MODE[mode_code][item.event_code];
        end
        if (nx != pmsm_pkg::NO_MODE) begin
          if (item.event_code == pmsm_pkg::EV_UNLOCK && !lock_next) begin
            refused = 1'b1;
          end else begin
            pending_next = pmsm_pkg::code_to_mode(nx);
            accepted     = 1'b1;
          end
        end
      end
    end else if (mode_reg != pending_reg) begin
      // exit actions of the mode being left
      unique case (mode_reg)
        pmsm_pkg::MODE_DEEPSLEEP, pmsm_pkg::MODE_SLEEP: begin
          enables_next = enables_next | pmsm_pkg::EN_BACKLIGHT;
        end
        pmsm_pkg::MODE_SAFETYLOCK: begin
          lock_next = 1'b0;
        end
        pmsm_pkg::MODE_MANUAL: begin
          enables_next = enables_next &
            ~(pmsm_pkg::EN_STPD | pmsm_pkg::EN_USBC2 | pmsm_pkg::EN_LAB);
        end
        default: begin
        end
      endcase
      mode_next = pending_reg;
      // entry actions of the new mode
      unique case (pending_reg)
        pmsm_pkg::MODE_DEEPSLEEP, pmsm_pkg::MODE_LOWV: begin
          enables_next = enables_next & ~(pmsm_pkg::EN_POWER | pmsm_pkg::EN_BACKLIGHT);
        end
        pmsm_pkg::MODE_SLEEP: begin
          enables_next = enables_next & ~pmsm_pkg::EN_BACKLIGHT;
        end
        pmsm_pkg::MODE_IDLE: begin
          enables_next = enables_next | pmsm_pkg::EN_RESET;
          chg          = item.charger_sinking;
          if (item.gauge_valid) begin
            if (item.state_of_charge < low_voltage_thr) begin
              soc = pmsm_pkg::SOC_LOWV;
            end else if (item.state_of_charge < safety_thr) begin
              soc = pmsm_pkg::SOC_SAFETY;
            end
          end
        end
        pmsm_pkg::MODE_SAFETYLOCK, pmsm_pkg::MODE_EMERGENCY: begin
          enables_next = enables_next & ~pmsm_pkg::EN_POWER;
        end
        pmsm_pkg::MODE_CHARGING: begin
          enables_next = enables_next & ~(pmsm_pkg::EN_USBA1 | pmsm_pkg::EN_USBA2 |
                                          pmsm_pkg::EN_USBC2 | pmsm_pkg::EN_STPD);
        end
        pmsm_pkg::MODE_MANUAL: begin
          enables_next = enables_next | pmsm_pkg::EN_LAB;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.current_mode        = pmsm_pkg::mode_to_code(mode_next);
    result.pending_mode        = pmsm_pkg::mode_to_code(pending_next);
    result.output_enables      = enables_next;
    result.overcharge_warning  = overcharge_next;
    result.user_lock_set       = lock_next;
    result.unlock_refused      = refused;
    result.transition_accepted = accepted;
    result.raise_charger_event = chg;
    result.raise_soc_event     = soc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= pmsm_pkg::MODE_IDLE;
      pending_reg     <= pmsm_pkg::MODE_IDLE;
      overcharge_reg  <= 1'b0;
      lock_reg        <= 1'b0;
      enables_reg     <= pmsm_pkg::EN_RESET;
      low_voltage_thr <= pmsm_pkg::LOW_VOLTAGE_RESET;
      safety_thr      <= pmsm_pkg::SAFETY_RESET;
    end else begin
      if (go) begin
        mode_reg       <= mode_next;
        pending_reg    <= pending_next;
        overcharge_reg <= overcharge_next;
        lock_reg       <= lock_next;
        enables_reg    <= enables_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          pmsm_pkg::CFG_LOW_VOLTAGE: low_voltage_thr <= cfg_data;
          pmsm_pkg::CFG_SAFETY:      safety_thr <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  a_mode_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !(go && item.command == pmsm_pkg::CMD_UPDATE) |=> $stable(mode_reg))
    else $error("mode changed without an update request");

  a_pending_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !(go && item.command == pmsm_pkg::CMD_FIRE) |=> $stable(pending_reg))
    else $error("pending mode changed without a fire request");

  a_lock_cleared_leaving_safetylock: assert property (@(posedge clk) disable iff (rst)
    (go && item.command == pmsm_pkg::CMD_UPDATE && mode_reg == pmsm_pkg::MODE_SAFETYLOCK &&
     pending_reg != pmsm_pkg::MODE_SAFETYLOCK) |=> !lock_reg)
    else $error("user lock kept after leaving safety lock");

endmodule

FILE: rtl/power_mode_state_machine.sv
// Top level of the power mode controller: request register, mode logic and result buffer.
//
// Requests arrive on cmd_valid/cmd_stall with command, event_code, charger_sinking,
// gauge_valid and state_of_charge; results leave on rsp_valid/rsp_stall, one per request,
// in order. A request is taken at an edge with valid high and stall low.
// A taken request waits in the request register until the result buffer has room, is then
// evaluated into the result buffer, and rsp_valid is high while the buffer holds a result.
// Throughput: one request per cycle while the result buffer has room; each request updates
// the mode, pending mode, flag and enable registers as it is evaluated.
// When the receiver stalls, the two-entry result buffer and the request register hold up
// to three requests; cmd_stall rises only when all three are occupied and is driven from
// registers alone.
// The threshold registers are written through cfg_write/cfg_index/cfg_data; index 0 is the
// low-voltage threshold, index 1 the safety threshold, other indexes are ignored.
// Reset: mode and pending mode idle, flags clear, USB-A ports and backlight enabled,
// thresholds 5 and 15 percent, request register and result buffer empty.
module power_mode_state_machine (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic       command,
  input  logic [4:0] event_code,
  input  logic       charger_sinking,
  input  logic       gauge_valid,
  input  logic [6:0] state_of_charge,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [3:0] current_mode,
  output logic [3:0] pending_mode,
  output logic [6:0] output_enables,
  output logic       overcharge_warning,
  output logic       user_lock_set,
  output logic       unlock_refused,
  output logic       transition_accepted,
  output logic       raise_charger_event,
  output logic [1:0] raise_soc_event
);

  logic           req_full;
  pmsm_pkg::cmd_t req;
  logic [1:0]     buf_cnt;
  pmsm_pkg::rsp_t buf0;
  pmsm_pkg::rsp_t buf1;
  pmsm_pkg::rsp_t result;
  logic           buf_full;
  logic           cmd_accept;
  logic           move;
  logic           pop;

  assign buf_full   = (buf_cnt == 2'd2);
  assign cmd_stall  = req_full && buf_full;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign move       = req_full && !buf_full;
  assign rsp_valid  = (buf_cnt != 2'd0);
  assign pop        = rsp_valid && !rsp_stall;

  pmsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (move),
    .item      (req),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      buf_cnt  <= 2'd0;
    end else begin
      req_full <= cmd_accept || (req_full && !move);
      buf_cnt  <= buf_cnt + {1'b0, move} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      req.command         <= command;
      req.event_code      <= event_code;
      req.charger_sinking <= charger_sinking;
      req.gauge_valid     <= gauge_valid;
      req.state_of_charge <= state_of_charge;
    end
    if (pop) begin
      if (move && buf_cnt == 2'd1) begin
        buf0 <= result;
      end else begin
        buf0 <= buf1;
      end
      if (move && buf_cnt == 2'd2) begin
        buf1 <= result;
      end
    end else if (move) begin
      if (buf_cnt == 2'd0) begin
        buf0 <= result;
      end else begin
        buf1 <= result;
      end
    end
  end

  assign current_mode        = buf0.current_mode;
  assign pending_mode        = buf0.pending_mode;
  assign output_enables      = buf0.output_enables;
  assign overcharge_warning  = buf0.overcharge_warning;
  assign user_lock_set       = buf0.user_lock_set;
  assign unlock_refused      = buf0.unlock_refused;
  assign transition_accepted = buf0.transition_accepted;
  assign raise_charger_event = buf0.raise_charger_event;
  assign raise_soc_event     = buf0.raise_soc_event;

  a_buf_no_overflow: assert property (@(posedge clk) disable iff (rst)
    buf_cnt != 2'd3)
    else $error("result buffer count out of range");

  a_accept_when_full_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd_accept && req_full) |-> move)
    else $error("request register overwritten before evaluation");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !move) |=> buf_cnt == $past(buf_cnt) - 2'd1)
    else $error("result buffer count not reduced after a take");

endmodule
